// ----- sv/ckbh_pkg.sv -----
`timescale 1ns / 1ps
package ckbh_pkg;

  localparam int unsigned KEY_W   = 8;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned BKT_W   = 20;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [KEY_W-1:0]   CHAR_LOWER_A = 8'h61;
  localparam logic [KEY_W-1:0]   CHAR_LOWER_Z = 8'h7A;
  localparam logic [KEY_W-1:0]   CASE_OFFSET  = 8'd32;
  localparam logic [KEY_W-1:0]   KEY_END      = 8'h00;
  localparam logic [SHIFT_W-1:0] SHIFT_STEP   = 5'd5;
  localparam logic [SHIFT_W-1:0] SHIFT_LIMIT  = 5'd25;
  localparam logic [SHIFT_W-1:0] SHIFT_DROP   = 5'd24;
  localparam logic [BKT_W-1:0]   BKT_RESET    = 20'd101;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- sv/ckbh_front.sv -----
`timescale 1ns / 1ps
module ckbh_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_accept,
  input  logic [ckbh_pkg::KEY_W-1:0]  key_byte,
  output logic                        push,
  output logic [ckbh_pkg::SUM_W-1:0]  push_sum
);
  import ckbh_pkg::*;

  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [KEY_W-1:0]   folded;
  logic [SUM_W-1:0]   term;
  logic [SHIFT_W-1:0] shift_step;
  logic               key_end;

  // fold lower case to upper case
  always_comb begin
    if (key_byte >= CHAR_LOWER_A && key_byte <= CHAR_LOWER_Z) begin
      folded = key_byte - CASE_OFFSET;
    end else begin
      folded = key_byte;
    end
  end

  // sign-extend and shift into place
  assign term = {{(SUM_W-KEY_W){folded[KEY_W-1]}}, folded} << shift_r;

  // shift walks 0,5,..,20 then wraps by 24
  always_comb begin
    shift_step = shift_r + SHIFT_STEP;
    if (shift_step >= SHIFT_LIMIT) begin
      shift_step = shift_step - SHIFT_DROP;
    end
  end

  assign key_end = (key_byte == KEY_END);

  always_comb begin
    sum_nxt   = sum_r;
    shift_nxt = shift_r;
    if (byte_accept) begin
      if (key_end) begin
        sum_nxt   = '0;
        shift_nxt = '0;
      end else begin
        sum_nxt   = sum_r + term;
        shift_nxt = shift_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      shift_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      shift_r <= shift_nxt;
    end
  end

  // finished key goes to the queue
  assign push     = byte_accept && key_end;
  assign push_sum = sum_r;

`ifndef SYNTHESIS
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    shift_r < SHIFT_LIMIT)
    else $error("shift amount out of range");
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (sum_r == '0 && shift_r == '0))
    else $error("state not cleared after key end");
`endif

endmodule

// ----- sv/ckbh_queue.sv -----
`timescale 1ns / 1ps
module ckbh_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [ckbh_pkg::SUM_W-1:0]  push_data,
  input  logic                        pop,
  output logic [ckbh_pkg::SUM_W-1:0]  pop_data,
  output ckbh_pkg::q_stat_t           stat
);
  import ckbh_pkg::*;

  logic [SUM_W-1:0]  mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // word storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/ckbh_back.sv -----
`timescale 1ns / 1ps
module ckbh_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ckbh_pkg::BKT_W-1:0]  bucket_count,
  input  ckbh_pkg::q_stat_t           q_stat,
  input  logic [ckbh_pkg::SUM_W-1:0]  q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ckbh_pkg::BKT_W-1:0]  out_index,
  output logic [ckbh_pkg::SUM_W-1:0]  out_sum
);
  import ckbh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  localparam int unsigned CNT_W = $clog2(SUM_W);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [BKT_W-1:0]   rem_r, rem_nxt;
  logic [BKT_W-1:0]   div_r, div_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BKT_W-1:0]   out_index_r, out_index_nxt;
  logic [SUM_W-1:0]   out_sum_r, out_sum_nxt;
  logic [BKT_W:0]     trial;
  logic [BKT_W:0]     trial_sub;
  logic               slot_free;

  // one restoring remainder step per cycle
  assign trial     = {rem_r, quo_r[SUM_W-1]};
  assign trial_sub = trial - {1'b0, div_r};
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    quo_nxt       = quo_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_index_nxt = out_index_r;
    out_sum_nxt   = out_sum_r;
    q_pop         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          quo_nxt   = q_data;
          sum_nxt   = q_data;
          rem_nxt   = '0;
          div_nxt   = bucket_count;
          cnt_nxt   = '0;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = trial_sub[BKT_W-1:0];
        end else begin
          rem_nxt = trial[BKT_W-1:0];
        end
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SUM_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = (div_r == '0) ? '0 : rem_r;
          out_sum_nxt   = sum_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    quo_r       <= quo_nxt;
    sum_r       <= sum_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    out_index_r <= out_index_nxt;
    out_sum_r   <= out_sum_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_sum   = out_sum_r;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && div_r != '0) |-> rem_r < div_r)
    else $error("remainder not below bucket count");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == ST_CALC && cnt_r == '0)
    else $error("pop did not start a reduction");
`endif

endmodule

// ----- sv/case_insensitive_key_bucket_hash.sv -----
`timescale 1ns / 1ps
// Path: a key-end word accepted on in_ goes through the queue, 32 remainder steps in
//   the bit-serial remainder unit, and the output register to out_.
// Throughput: one key byte per cycle while the queue has room; the remainder unit
//   takes one sum at a time, so a 4-word queue lets the front run ahead of it.
// Reset: rst_n synchronous active low; clears sum, shift, queue, back state,
//   output valid, and sets bucket_count to 101.
module case_insensitive_key_bucket_hash (
  input  logic                              clk,
  input  logic                              rst_n,
  // cfg: bucket_count
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ckbh_pkg::BKT_W-1:0]        cfg_data,
  // in_tdata: [7:0] key_byte
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ckbh_pkg::KEY_W-1:0]        in_tdata,
  // out_tdata: [19:0] bucket_index, [51:20] hash_sum, [55:52] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ckbh_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import ckbh_pkg::*;

  logic [BKT_W-1:0] bucket_count_r, bucket_count_nxt;
  logic             byte_accept;
  logic             push;
  logic [SUM_W-1:0] push_sum;
  logic             q_pop;
  logic [SUM_W-1:0] q_data;
  q_stat_t          q_stat;
  logic [BKT_W-1:0] out_index;
  logic [SUM_W-1:0] out_sum;

  // configuration register
  assign cfg_ready        = 1'b1;
  assign bucket_count_nxt = (cfg_valid && cfg_ready) ? cfg_data : bucket_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BKT_RESET;
    end else begin
      bucket_count_r <= bucket_count_nxt;
    end
  end

  // take bytes while the queue has room
  assign in_tready   = !q_stat.full;
  assign byte_accept = in_tvalid && in_tready;

  ckbh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (byte_accept),
    .key_byte    (in_tdata),
    .push        (push),
    .push_sum    (push_sum)
  );

  ckbh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_sum),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  ckbh_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .bucket_count (bucket_count_r),
    .q_stat       (q_stat),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_index    (out_index),
    .out_sum      (out_sum)
  );

  assign out_tdata = {(OUT_TDATA_W-SUM_W-BKT_W)'(0), out_sum, out_index};

endmodule
